>>> rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, screen geometry and character codes of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	// screen geometry
	localparam int SCREEN_ROWS    = 25;
	localparam int SCREEN_COLUMNS = 80;
	localparam int SCREEN_CELLS   = SCREEN_ROWS * SCREEN_COLUMNS;
	localparam int ADDR_W         = $clog2(SCREEN_CELLS);

	// field widths of the command and result beats
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CHAR_W = 8;
	localparam int CELL_W = 16;

	// cursor and address limits
	localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(SCREEN_ROWS - 1);
	localparam logic [ROW_W-1:0]  PENDING_ROW = ROW_W'(SCREEN_ROWS);
	localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(SCREEN_COLUMNS - 1);
	localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(SCREEN_COLUMNS);
	localparam logic [ADDR_W-1:0] COPY_END    = ADDR_W'((SCREEN_ROWS - 1) * SCREEN_COLUMNS);
	localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(SCREEN_CELLS - 1);

	// character codes and cell values
	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
	localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'd32;
	localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
	localparam logic [7:0]        COLOR_RESET  = 8'd7;

	// operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef struct packed {
		logic              operation;
		logic [CHAR_W-1:0] character;
		logic [ROW_W-1:0]  read_row;
		logic [COL_W-1:0]  read_column;
	} cmd_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_entry;
		logic [ROW_W-1:0]  cursor_row_out;
		logic [COL_W-1:0]  cursor_column_out;
		logic              did_scroll;
	} rsp_t;

	// screen memory access from the sequencer
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COPY,
		ST_FILL,
		ST_WRITE,
		ST_READ
	} state_t;

endpackage

`default_nettype wire

>>> rtl/tcw_screen_ram.sv
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Screen cell memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_screen_ram (
	input  wire logic                      clk,
	input  wire tcw_pkg::ram_req_t         req,
	output logic [tcw_pkg::CELL_W-1:0]     rdata
);

	logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::SCREEN_CELLS];

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[req.raddr];
	end

endmodule

`default_nettype wire

>>> rtl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: clear pass, scroll walk, cell write and cell read, with cursor.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire tcw_pkg::cmd_t             command,
	input  wire logic [7:0]                color,
	input  wire logic [tcw_pkg::CELL_W-1:0] rdata,
	output tcw_pkg::ram_req_t              ram_req,
	output logic                           busy,
	output logic                           done,
	output tcw_pkg::rsp_t                  result
);

	tcw_pkg::state_t                 state_q, state_d;
	logic [tcw_pkg::ADDR_W-1:0]      ptr_q;
	logic [tcw_pkg::ROW_W-1:0]       row_q;
	logic [tcw_pkg::COL_W-1:0]       col_q;
	logic                            scrolled_q;
	logic                            done_q;
	tcw_pkg::cmd_t                   cmd_q;
	tcw_pkg::rsp_t                   result_q;

	logic                            accept;
	logic                            read_in_range;
	logic [tcw_pkg::ROW_W-1:0]       unit_row;
	logic [tcw_pkg::COL_W-1:0]       unit_col;
	logic [tcw_pkg::ADDR_W-1:0]      cell_addr;
	logic [tcw_pkg::ROW_W-1:0]       next_row;
	logic [tcw_pkg::COL_W-1:0]       next_col;

	assign accept = start && (state_q == tcw_pkg::ST_IDLE);
	assign read_in_range = (command.read_row < tcw_pkg::PENDING_ROW) &&
		(command.read_column <= tcw_pkg::LAST_COL);

	// shared address unit: row * columns + column
	always_comb begin
		if (state_q == tcw_pkg::ST_IDLE) begin
			unit_row = command.read_row;
			unit_col = command.read_column;
		end else begin
			unit_row = row_q;
			unit_col = col_q;
		end
		cell_addr = tcw_pkg::ADDR_W'(unit_row) * tcw_pkg::ROW_STRIDE +
			tcw_pkg::ADDR_W'(unit_col);
	end

	// cursor after a character write
	always_comb begin
		if (cmd_q.character == tcw_pkg::NEWLINE_CHAR || col_q == tcw_pkg::LAST_COL) begin
			next_row = row_q + 1'b1;
			next_col = '0;
		end else begin
			next_row = row_q;
			next_col = col_q + 1'b1;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tcw_pkg::ST_CLEAR: begin
				if (ptr_q == tcw_pkg::LAST_CELL) state_d = tcw_pkg::ST_IDLE;
			end
			tcw_pkg::ST_IDLE: begin
				if (start) begin
					if (command.operation == tcw_pkg::OP_READ) begin
						if (read_in_range) state_d = tcw_pkg::ST_READ;
					end else if (row_q == tcw_pkg::PENDING_ROW) begin
						state_d = tcw_pkg::ST_COPY;
					end else begin
						state_d = tcw_pkg::ST_WRITE;
					end
				end
			end
			tcw_pkg::ST_COPY: begin
				if (ptr_q == tcw_pkg::COPY_END) state_d = tcw_pkg::ST_FILL;
			end
			tcw_pkg::ST_FILL: begin
				if (ptr_q == tcw_pkg::LAST_CELL) state_d = tcw_pkg::ST_WRITE;
			end
			tcw_pkg::ST_WRITE: state_d = tcw_pkg::ST_IDLE;
			tcw_pkg::ST_READ:  state_d = tcw_pkg::ST_IDLE;
			default:           state_d = tcw_pkg::ST_CLEAR;
		endcase
	end

	// memory port control
	always_comb begin
		ram_req.we    = 1'b0;
		ram_req.waddr = ptr_q;
		ram_req.wdata = tcw_pkg::BLANK_CELL;
		ram_req.raddr = ptr_q + tcw_pkg::ROW_STRIDE;
		unique case (state_q)
			tcw_pkg::ST_CLEAR: begin
				ram_req.we = 1'b1;
			end
			tcw_pkg::ST_IDLE: begin
				ram_req.raddr = cell_addr;
			end
			tcw_pkg::ST_COPY: begin
				// read one row ahead, write the cell fetched last cycle
				ram_req.we    = (ptr_q != '0);
				ram_req.waddr = ptr_q - 1'b1;
				ram_req.wdata = rdata;
			end
			tcw_pkg::ST_FILL: begin
				ram_req.we    = 1'b1;
				ram_req.wdata = {color, tcw_pkg::SPACE_CHAR};
			end
			tcw_pkg::ST_WRITE: begin
				ram_req.we    = (cmd_q.character != tcw_pkg::NEWLINE_CHAR);
				ram_req.waddr = cell_addr;
				ram_req.wdata = {color, cmd_q.character};
			end
			tcw_pkg::ST_READ: begin
				ram_req.raddr = cell_addr;
			end
			default: begin
				ram_req.we = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tcw_pkg::ST_CLEAR;
			ptr_q      <= '0;
			row_q      <= '0;
			col_q      <= '0;
			scrolled_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				tcw_pkg::ST_CLEAR: begin
					ptr_q  <= ptr_q + 1'b1;
					done_q <= 1'b0;
				end
				tcw_pkg::ST_IDLE: begin
					ptr_q      <= '0;
					scrolled_q <= 1'b0;
					done_q     <= accept && command.operation == tcw_pkg::OP_READ &&
						!read_in_range;
				end
				tcw_pkg::ST_COPY: begin
					if (ptr_q != tcw_pkg::COPY_END) ptr_q <= ptr_q + 1'b1;
					done_q <= 1'b0;
				end
				tcw_pkg::ST_FILL: begin
					ptr_q  <= ptr_q + 1'b1;
					done_q <= 1'b0;
					if (ptr_q == tcw_pkg::LAST_CELL) begin
						row_q      <= tcw_pkg::LAST_ROW;
						scrolled_q <= 1'b1;
					end
				end
				tcw_pkg::ST_WRITE: begin
					row_q  <= next_row;
					col_q  <= next_col;
					done_q <= 1'b1;
				end
				tcw_pkg::ST_READ: begin
					done_q <= 1'b1;
				end
				default: begin
					ptr_q  <= '0;
					done_q <= 1'b0;
				end
			endcase
		end
	end

	// command capture and result beat
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			result_q.cell_entry        <= '0;
			result_q.cursor_row_out    <= row_q;
			result_q.cursor_column_out <= col_q;
			result_q.did_scroll        <= 1'b0;
		end
		if (state_q == tcw_pkg::ST_WRITE) begin
			result_q.cell_entry        <= '0;
			result_q.cursor_row_out    <= next_row;
			result_q.cursor_column_out <= next_col;
			result_q.did_scroll        <= scrolled_q;
		end
		if (state_q == tcw_pkg::ST_READ) begin
			result_q.cell_entry        <= rdata;
			result_q.cursor_row_out    <= row_q;
			result_q.cursor_column_out <= col_q;
			result_q.did_scroll        <= 1'b0;
		end
	end

	assign busy   = (state_q != tcw_pkg::ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

>>> rtl/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core
// Character-cell text screen with cursor, scrolling and cell readback.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 2000-cell screen to grey spaces, one cell a
// cycle, and holds busy high for the whole sweep. A command is taken when
// start is high and busy is low. A character write or a cell read then runs
// through the write or read state; a write that finds a scroll pending first
// walks the screen through the memory, one cell a cycle: the row copy, then
// the blank last row, then the write. Reads outside the screen answer in the
// next cycle and never raise busy. Each result beat shows on result for one
// cycle with done high, in the cycle busy drops if it rose; the receiver
// cannot hold it off, so it must take every beat as it comes.
// text_color is written on the cfg channel, which is always ready and must
// only be used while the block is idle.
`default_nettype none

module text_console_writer_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire tcw_pkg::cmd_t command,
	output logic               busy,
	output logic               done,
	output tcw_pkg::rsp_t      result,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [7:0]    cfg_data
);

	logic [7:0]                  color_q;
	tcw_pkg::ram_req_t           ram_req;
	logic [tcw_pkg::CELL_W-1:0]  ram_rdata;

	// text color register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= tcw_pkg::COLOR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			color_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	tcw_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.color   (color_q),
		.rdata   (ram_rdata),
		.ram_req (ram_req),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	tcw_screen_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

>>> rtl/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire logic          done,
	input wire tcw_pkg::rsp_t result
);

	// an accepted command keeps the block busy or answers at once
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted command neither busy nor answered");

	// reported cursor stays on the screen or one row below it
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.cursor_row_out <= tcw_pkg::PENDING_ROW) &&
			(result.cursor_column_out <= tcw_pkg::LAST_COL))
		else $error("cursor out of range");

	// a scroll leaves the cursor on the last row or past it, and returns no cell
	a_scroll_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.did_scroll |->
			(result.cursor_row_out == tcw_pkg::LAST_ROW ||
			 result.cursor_row_out == tcw_pkg::PENDING_ROW) &&
			(result.cell_entry == '0))
		else $error("bad scroll beat");

	// a result beat never comes while a long command is still running
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy || $past(start && !busy))
		else $error("result beat while busy");

endmodule

bind text_console_writer_core tcw_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console writer core. A shadow screen,
// cursor and color register predict every response beat; directed tests cover
// reset contents, byte extremes, newline, color extremes and out-of-screen
// reads. Random traffic is then sent as text lines of random length, which
// wrap, reach the bottom row and scroll. Reads and stray bytes are mixed in,
// under three levels of sender idling and three color settings.
// ----------------------------------------------------------------------------

module tb_top;
	import tcw_pkg::*;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       start     = 1'b0;
	cmd_t       command   = '0;
	logic       cfg_valid = 1'b0;
	logic [7:0] cfg_data  = '0;
	logic       busy;
	logic       done;
	logic       cfg_ready;
	rsp_t       result;

	// shadow copy of the screen, cursor and color
	logic [CELL_W-1:0] shadow_screen [SCREEN_CELLS];
	logic [ROW_W-1:0]  shadow_row;
	logic [COL_W-1:0]  shadow_col;
	logic [7:0]        shadow_color;

	rsp_t pending_responses [$];
	int   mismatch_count = 0;

	text_console_writer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.command   (command),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// cursor to column 0 of the next row, stopping at the pending row
	function automatic void shadow_next_row();
		shadow_col = '0;
		if (shadow_row < PENDING_ROW)
			shadow_row = shadow_row + 1'b1;
	endfunction

	// apply one command to the shadow state and return the response it gives
	function automatic rsp_t console_response(input cmd_t c);
		rsp_t r;
		r = '0;
		if (c.operation == OP_READ) begin
			if (c.read_row < SCREEN_ROWS && c.read_column < SCREEN_COLUMNS)
				r.cell_entry = shadow_screen[c.read_row * SCREEN_COLUMNS + c.read_column];
		end else begin
			// pending scroll: rows move up, last row blanks in the current color
			if (shadow_row >= PENDING_ROW) begin
				for (int i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLUMNS; i++)
					shadow_screen[i] = shadow_screen[i + SCREEN_COLUMNS];
				for (int i = 0; i < SCREEN_COLUMNS; i++)
					shadow_screen[(SCREEN_ROWS - 1) * SCREEN_COLUMNS + i] =
						{shadow_color, SPACE_CHAR};
				shadow_row   = LAST_ROW;
				r.did_scroll = 1'b1;
			end
			if (c.character == NEWLINE_CHAR) begin
				shadow_next_row();
			end else begin
				shadow_screen[shadow_row * SCREEN_COLUMNS + shadow_col] =
					{shadow_color, c.character};
				if (shadow_col == LAST_COL)
					shadow_next_row();
				else
					shadow_col = shadow_col + 1'b1;
			end
		end
		r.cursor_row_out    = shadow_row;
		r.cursor_column_out = shadow_col;
		return r;
	endfunction

	function automatic cmd_t write_beat(input logic [CHAR_W-1:0] ch);
		cmd_t c;
		c.operation   = OP_WRITE;
		c.character   = ch;
		c.read_row    = ROW_W'($urandom);
		c.read_column = COL_W'($urandom);
		return c;
	endfunction

	function automatic cmd_t read_beat(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		cmd_t c;
		c.operation   = OP_READ;
		c.character   = CHAR_W'($urandom);
		c.read_row    = row;
		c.read_column = col;
		return c;
	endfunction

	// hold start until the core takes the beat, then queue its response
	task automatic send_command(input cmd_t c);
		start   <= 1'b1;
		command <= c;
		do @(posedge clk); while (busy);
		pending_responses.push_back(console_response(c));
	endtask

	// random gap after a beat, of geometric length
	task automatic pause_sender(input int idle_pct);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_responses.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// color register is only written with the core idle
	task automatic write_text_color(input logic [7:0] color);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= color;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid    <= 1'b0;
		shadow_color  = color;
	endtask

	// screen after reset, corners and reads off the screen
	task automatic test_reset_contents();
		send_command(read_beat(ROW_W'(0), COL_W'(0)));
		send_command(read_beat(LAST_ROW, LAST_COL));
		send_command(read_beat(ROW_W'(12), COL_W'(40)));
		send_command(read_beat(PENDING_ROW, COL_W'(0)));
		send_command(read_beat(ROW_W'(0), COL_W'(SCREEN_COLUMNS)));
		send_command(read_beat('1, '1));
		pause_sender(36);
	endtask

	// byte extremes, newline and color extremes, then read back
	task automatic test_write_extremes();
		send_command(write_beat(8'h00));
		write_text_color(8'hFF);
		send_command(write_beat(8'hFF));
		send_command(write_beat(NEWLINE_CHAR));
		write_text_color(8'h00);
		send_command(write_beat(8'h41));
		send_command(read_beat(ROW_W'(0), COL_W'(0)));
		send_command(read_beat(ROW_W'(0), COL_W'(1)));
		send_command(read_beat(ROW_W'(1), COL_W'(0)));
		send_command(read_beat(ROW_W'(1), COL_W'(1)));
		pause_sender(36);
	endtask

	// text lines of random length with reads and stray bytes mixed in
	task automatic test_random_traffic(input int idle_pct, input int beats);
		int                line_left;
		logic [CHAR_W-1:0] ch;
		line_left = $urandom_range(30);
		repeat (beats) begin
			if ($urandom_range(99) < 22) begin
				if ($urandom_range(4) != 0)
					send_command(read_beat(ROW_W'($urandom_range(SCREEN_ROWS - 1)),
						COL_W'($urandom_range(SCREEN_COLUMNS - 1))));
				else
					send_command(read_beat(ROW_W'($urandom), COL_W'($urandom)));
			end else if ($urandom_range(99) < 4) begin
				send_command(write_beat(CHAR_W'($urandom)));
			end else if (line_left == 0) begin
				send_command(write_beat(NEWLINE_CHAR));
				line_left = ($urandom_range(9) == 0) ? $urandom_range(170) : $urandom_range(30);
			end else begin
				ch = CHAR_W'($urandom);
				if (ch == NEWLINE_CHAR)
					ch = SPACE_CHAR;
				send_command(write_beat(ch));
				line_left--;
			end
			pause_sender(idle_pct);
		end
	endtask

	// response checker: every done beat against the oldest expectation
	always @(posedge clk) begin : check_responses
		rsp_t want;
		if (arst_n && done) begin
			if (pending_responses.size() == 0) begin
				$display("%0t: response beat with nothing pending, expected none actual %h",
					$time, result);
				mismatch_count++;
			end else begin
				want = pending_responses.pop_front();
				if (result.cell_entry !== want.cell_entry) begin
					$display("%0t: cell_entry expected %h actual %h",
						$time, want.cell_entry, result.cell_entry);
					mismatch_count++;
				end
				if (result.cursor_row_out !== want.cursor_row_out) begin
					$display("%0t: cursor_row_out expected %0d actual %0d",
						$time, want.cursor_row_out, result.cursor_row_out);
					mismatch_count++;
				end
				if (result.cursor_column_out !== want.cursor_column_out) begin
					$display("%0t: cursor_column_out expected %0d actual %0d",
						$time, want.cursor_column_out, result.cursor_column_out);
					mismatch_count++;
				end
				if (result.did_scroll !== want.did_scroll) begin
					$display("%0t: did_scroll expected %b actual %b",
						$time, want.did_scroll, result.did_scroll);
					mismatch_count++;
				end
			end
		end
	end

	// test sequence
	initial begin
		foreach (shadow_screen[i])
			shadow_screen[i] = BLANK_CELL;
		shadow_row   = '0;
		shadow_col   = '0;
		shadow_color = COLOR_RESET;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_contents();
		test_write_extremes();
		write_text_color(8'($urandom_range(255)));
		test_random_traffic(36, 585);
		write_text_color(8'h00);
		test_random_traffic(82, 585);
		write_text_color(8'hFF);
		test_random_traffic(0, 585);

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// run limit, far beyond a run where every write scrolls
	initial begin
		#50_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
